### hw/rtl/nalsplit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nalsplit_pkg;

  // Byte values that matter to the start code search.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // NAL header decoding.
  localparam logic [4:0] TYPE_MASK = 5'h1f;
  localparam logic [4:0] TYPE_SEI  = 5'h06;

  // Width of the unit length field on the output.
  localparam int OUT_LEN_W = 24;

  // Result queue sizing: one input byte produces at most five results.
  localparam int MAX_RESULTS = 5;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  // Register word indexes on the configuration port.
  localparam logic REG_DROP_SEI = 1'b0;

  // One result as it sits in the output queue.
  typedef struct packed {
    logic [7:0]           payload_byte;
    logic [4:0]           unit_type;
    logic                 unit_first;
    logic                 unit_last;
    logic [OUT_LEN_W-1:0] unit_length;
    logic                 run_last;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/h264_nal_unit_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// Splits an H.264 Annex B byte stream into NAL units. Input bytes arrive on the s_ side
// with tlast marking the end of the stream; start codes and any bytes before the first
// start code are removed, and each unit byte leaves on the m_ side with the unit type,
// first/last marks and, on the last byte, the saturating unit length. SEI units are
// dropped while register 0 bit 0 is set (the default). Each accepted byte is parsed in
// the cycle it is taken and its zero to five results are written at once into an
// eight-entry result queue, so with the queue empty the first result is visible in
// the cycle after the beat. The input takes one byte per clock whenever the queue has
// room for five results; because every stream byte is output at most once, a stream
// drains at one byte per clock while m_tready is high; the input stalls without that
// room. The last payload byte and up to three trailing zeros of a unit are held back
// until the next start code or the end of the stream shows whether they belong to it.
module h264_nal_unit_splitter #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tlast,   // stream_end
  // Output unit bytes.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [31:8] unit_length
  output logic        m_tlast,   // unit_last
  output logic [6:0]  m_tuser,   // [4:0] unit_type, [5] unit_first, [6] run_last
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Configuration register.
  logic drop_sei;

  // Parser state.
  logic                   inside_unit;
  logic [1:0]             zero_run;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic [4:0]             current_type;
  logic                   suppressing;
  logic [LENGTH_BITS-1:0] length_count;
  logic                   awaiting_header;

  // Result queue.
  nalsplit_pkg::result_t                   fifo [nalsplit_pkg::FIFO_DEPTH];
  logic [nalsplit_pkg::PTR_W-1:0]          wr_ptr;
  logic [nalsplit_pkg::PTR_W-1:0]          rd_ptr;
  logic [nalsplit_pkg::CNT_W-1:0]          count;
  nalsplit_pkg::result_t                   head;

  // Per beat decode.
  logic                   in_beat;
  logic                   out_beat;
  logic                   is_zero;
  logic                   is_start;
  logic                   case_zero_full;
  logic                   case_zero_more;
  logic                   case_start;
  logic                   case_data;
  logic [2:0]             total;
  logic [2:0]             emit_n;
  logic                   tail_is_input;
  logic                   header_now;
  logic [7:0]             slot0_byte;
  logic [4:0]             type_next;
  logic                   supp_next;
  logic [LENGTH_BITS-1:0] len_base;
  logic [LENGTH_BITS+2:0] len_sum;
  logic [LENGTH_BITS-1:0] length_next;
  nalsplit_pkg::result_t  rec [nalsplit_pkg::MAX_RESULTS];

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign s_tready = (count <= nalsplit_pkg::CNT_W'(nalsplit_pkg::FIFO_DEPTH
                                                  - nalsplit_pkg::MAX_RESULTS));

  // Configuration port: writes complete in the access phase, reads are direct.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == nalsplit_pkg::REG_DROP_SEI) begin
      prdata[0] = drop_sei;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_sei <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nalsplit_pkg::REG_DROP_SEI) begin
      drop_sei <= pwdata[0];
    end
  end

  // Classify the incoming byte against the parser state.
  assign is_zero        = (s_tdata == nalsplit_pkg::BYTE_ZERO);
  assign is_start       = (s_tdata == nalsplit_pkg::BYTE_ONE) && zero_run[1];
  assign case_zero_full = inside_unit && is_zero && (zero_run == 2'd3);
  assign case_zero_more = inside_unit && is_zero && (zero_run != 2'd3);
  assign case_start     = inside_unit && !is_zero && is_start;
  assign case_data      = inside_unit && !is_zero && !is_start;

  // Number of bytes released by this beat, the held byte always first when present.
  always_comb begin
    total = '0;
    if (case_zero_full) begin
      total = {2'b00, held_valid} + (s_tlast ? 3'd4 : 3'd0);
    end else if (case_zero_more) begin
      if (s_tlast) begin
        total = {2'b00, held_valid} + {1'b0, zero_run} + 3'd1;
      end
    end else if (case_start) begin
      total = {2'b00, held_valid};
    end else if (case_data) begin
      total = {2'b00, held_valid} + {1'b0, zero_run} + {2'b00, s_tlast};
    end
  end

  // A data byte at stream end is flushed right away as the final byte.
  assign tail_is_input = case_data && s_tlast;
  assign slot0_byte    = held_valid ? held_byte :
                         (tail_is_input && total == 3'd1) ? s_tdata : nalsplit_pkg::BYTE_ZERO;

  // The header can only be the first byte released by a beat.
  assign header_now = awaiting_header && (total != 3'd0);
  assign type_next  = header_now ? (slot0_byte[4:0] & nalsplit_pkg::TYPE_MASK) : current_type;
  assign supp_next  = header_now ? (drop_sei && type_next == nalsplit_pkg::TYPE_SEI)
                                 : suppressing;
  assign len_base   = header_now ? '0 : length_count;
  assign emit_n     = supp_next ? 3'd0 : total;

  // Unit length after all bytes of this beat, saturating.
  assign len_sum     = {3'b000, len_base} + (LENGTH_BITS+3)'(total);
  assign length_next = (len_sum[LENGTH_BITS+2:LENGTH_BITS] != 3'b000) ? LEN_MAX
                                                                       : len_sum[LENGTH_BITS-1:0];

  // Build the result records for every slot.
  always_comb begin
    logic [LENGTH_BITS+2:0] sum;
    logic [LENGTH_BITS-1:0] sat;
    logic                   is_final;
    for (int i = 0; i < nalsplit_pkg::MAX_RESULTS; i++) begin
      sum      = {3'b000, len_base} + (LENGTH_BITS+3)'(i + 1);
      sat      = (sum[LENGTH_BITS+2:LENGTH_BITS] != 3'b000) ? LEN_MAX
                                                            : sum[LENGTH_BITS-1:0];
      is_final = (3'(i) == total - 3'd1);
      if (i == 0 && held_valid) begin
        rec[i].payload_byte = held_byte;
      end else if (tail_is_input && is_final) begin
        rec[i].payload_byte = s_tdata;
      end else begin
        rec[i].payload_byte = nalsplit_pkg::BYTE_ZERO;
      end
      rec[i].unit_type   = type_next;
      rec[i].unit_first  = (i == 0) && header_now;
      rec[i].unit_last   = is_final && (s_tlast || case_start);
      rec[i].unit_length = rec[i].unit_last ? nalsplit_pkg::OUT_LEN_W'(sat) : '0;
      rec[i].run_last    = is_final;
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_unit     <= 1'b0;
      zero_run        <= '0;
      held_byte       <= '0;
      held_valid      <= 1'b0;
      current_type    <= '0;
      suppressing     <= 1'b0;
      length_count    <= '0;
      awaiting_header <= 1'b0;
    end else if (in_beat) begin
      if (s_tlast) begin
        // Stream end flushes everything and starts a fresh search.
        inside_unit     <= 1'b0;
        zero_run        <= '0;
        held_byte       <= '0;
        held_valid      <= 1'b0;
        current_type    <= '0;
        suppressing     <= 1'b0;
        length_count    <= '0;
        awaiting_header <= 1'b0;
      end else begin
        if (total != 3'd0) begin
          current_type <= type_next;
          suppressing  <= supp_next;
          length_count <= length_next;
          if (!case_start) begin
            awaiting_header <= 1'b0;
          end
        end
        if (!inside_unit) begin
          if (is_start) begin
            inside_unit     <= 1'b1;
            awaiting_header <= 1'b1;
            held_valid      <= 1'b0;
            zero_run        <= '0;
          end else if (is_zero) begin
            if (zero_run != 2'd3) begin
              zero_run <= zero_run + 2'd1;
            end
          end else begin
            zero_run <= '0;
          end
        end else if (case_zero_full) begin
          held_byte  <= nalsplit_pkg::BYTE_ZERO;
          held_valid <= 1'b1;
        end else if (case_zero_more) begin
          zero_run <= zero_run + 2'd1;
        end else if (case_start) begin
          held_valid      <= 1'b0;
          zero_run        <= '0;
          awaiting_header <= 1'b1;
        end else begin
          zero_run   <= '0;
          held_byte  <= s_tdata;
          held_valid <= 1'b1;
        end
      end
    end
  end

  // Result queue storage: up to five writes per beat at consecutive slots.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int i = 0; i < nalsplit_pkg::MAX_RESULTS; i++) begin
        if (3'(i) < emit_n) begin
          fifo[wr_ptr + nalsplit_pkg::PTR_W'(i)] <= rec[i];
        end
      end
    end
  end

  // Result queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_beat) begin
        wr_ptr <= wr_ptr + nalsplit_pkg::PTR_W'(emit_n);
      end
      if (out_beat) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (in_beat ? nalsplit_pkg::CNT_W'(emit_n) : '0)
                     - nalsplit_pkg::CNT_W'(out_beat);
    end
  end

  // Output beat from the queue head.
  assign head     = fifo[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = {head.unit_length, head.payload_byte};
  assign m_tlast  = head.unit_last;
  assign m_tuser  = {head.run_last, head.unit_first, head.unit_type};

endmodule

`default_nettype wire

### hw/rtl/nalsplit_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nalsplit_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire        m_tlast,
  input wire [6:0]  m_tuser
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat offered right after reset");

  // The last byte of a unit always closes the results of its input beat.
  a_last_closes_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[6])
    else $error("unit end without run end");

  // The header byte carries its own type.
  a_header_type: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[5]) |-> (m_tuser[4:0] == m_tdata[4:0]))
    else $error("header byte type mismatch");

  // Length is only reported on the last byte of a unit.
  a_length_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[31:8] == 24'd0))
    else $error("unit length on a non-final byte");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind h264_nal_unit_splitter nalsplit_checker u_nalsplit_checker (.*);

`default_nettype wire
